@@ rtl/prdg_pkg.sv @@
`timescale 1ns / 1ps
package prdg_pkg;

   localparam int MAX_IMAGE_DIM = 4096;
   localparam int FRAC_BITS     = 16;
   localparam int ROT_FRAC      = 14;
   localparam int OUT_W         = 11 + FRAC_BITS;
   localparam int ROW_W         = 48;
   localparam int ROT_W         = 16;
   localparam int SIZE_W        = 24;
   localparam int DIM_W         = 13;
   localparam int PIX_W         = 12;
   localparam int CSR_ADDR_W    = 4;
   localparam int SPAN_W        = 15;
   localparam int PROD_W        = SIZE_W + 1 + SPAN_W;
   localparam int NUM_W         = 37;
   localparam int DEN_W         = 14;
   localparam int DIV_STAGES    = NUM_W;
   localparam int PT_W          = NUM_W + 1;
   localparam int MUL_W         = PT_W + ROT_W;
   localparam int ACC_W         = MUL_W + 2;
   localparam int SHR_W         = ACC_W - ROT_FRAC;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ROT_ROW0  = 4'd0,
      REG_ROT_ROW1  = 4'd1,
      REG_ROT_ROW2  = 4'd2,
      REG_SCREEN_W  = 4'd3,
      REG_SCREEN_H  = 4'd4,
      REG_FOCAL     = 4'd5,
      REG_IMAGE_W   = 4'd6,
      REG_IMAGE_H   = 4'd7
   } csr_index_type;

   localparam logic [ROW_W-1:0]  ROW0_RESET  = 48'h4000_0000_0000;
   localparam logic [ROW_W-1:0]  ROW1_RESET  = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0]  ROW2_RESET  = 48'h0000_0000_4000;
   localparam logic [SIZE_W-1:0] SIZE_RESET  = 24'h01_0000;
   localparam logic [DIM_W-1:0]  IMW_RESET   = 13'd640;
   localparam logic [DIM_W-1:0]  IMH_RESET   = 13'd480;

   // Zero is treated as one, anything above the maximum as the maximum.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) r = DIM_W'(1);
      else if (d > DIM_W'(MAX_IMAGE_DIM)) r = DIM_W'(MAX_IMAGE_DIM);
      else r = d;
      return r;
   endfunction

endpackage

@@ rtl/primary_ray_direction_generator_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one beat per cycle unless a waiting rsp beat stalls the pipe; the
// 37-stage pipelined bit-per-stage divider (one per screen axis) sets the latency, every stage advances together.
// Reset (synchronous, active high) clears all valid bits and loads the
// identity rotation, 1.0 screen size and focal distance, and a 640x480 image.
module primary_ray_direction_generator_unit import prdg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIX_W-1:0]        req_pixel_x,
   input  logic [PIX_W-1:0]        req_pixel_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_dir_x,
   output logic signed [OUT_W-1:0] rsp_dir_y,
   output logic signed [OUT_W-1:0] rsp_dir_z,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ROW_W-1:0]        csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [ROW_W-1:0]  rot_ff [3];
   logic [SIZE_W-1:0] sw_ff, sh_ff, zf_ff;
   logic [DIM_W-1:0]  iw_ff, ih_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROW0_RESET;
         rot_ff[1] <= ROW1_RESET;
         rot_ff[2] <= ROW2_RESET;
         sw_ff     <= SIZE_RESET;
         sh_ff     <= SIZE_RESET;
         zf_ff     <= SIZE_RESET;
         iw_ff     <= IMW_RESET;
         ih_ff     <= IMH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ROT_ROW0: rot_ff[0] <= csr_wdata;
            REG_ROT_ROW1: rot_ff[1] <= csr_wdata;
            REG_ROT_ROW2: rot_ff[2] <= csr_wdata;
            REG_SCREEN_W: sw_ff     <= csr_wdata[SIZE_W-1:0];
            REG_SCREEN_H: sh_ff     <= csr_wdata[SIZE_W-1:0];
            REG_FOCAL:    zf_ff     <= csr_wdata[SIZE_W-1:0];
            REG_IMAGE_W:  iw_ff     <= csr_wdata[DIM_W-1:0];
            REG_IMAGE_H:  ih_ff     <= csr_wdata[DIM_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Clamped image size and the divisor 2*n. The user must keep config static
   // while busy (the block does not enforce it); every stage reads these directly.
   logic [DIM_W-1:0] n_dim [2];
   logic [DEN_W-1:0] den   [2];
   logic [SIZE_W-1:0] size [2];

   always_comb begin
      n_dim[0] = clamp_dim(iw_ff);
      n_dim[1] = clamp_dim(ih_ff);
      den[0]   = {n_dim[0], 1'b0};
      den[1]   = {n_dim[1], 1'b0};
      size[0]  = sw_ff;
      size[1]  = sh_ff;
   end

   // ---------------- stall control ----------------
   // The whole pipe advances as one; hold everything while a rsp beat waits.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: capture pixel ----------------
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff [2];

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_valid;
      if (adv) begin
         s1_pix_ff[0] <= req_pixel_x;
         s1_pix_ff[1] <= req_pixel_y;
      end
   end

   // ---------------- stage 2: span = n - 2*pix - 1 ----------------
   logic                     s2_valid_ff;
   logic signed [SPAN_W-1:0] s2_span_ff [2];
   logic signed [SPAN_W-1:0] s2_span_in [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         s2_span_in[a] = $signed(SPAN_W'(n_dim[a]))
                       - $signed(SPAN_W'({s1_pix_ff[a], 1'b0}))
                       - $signed(SPAN_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
      if (adv) s2_span_ff <= s2_span_in;
   end

   // ---------------- stage 3: numerator = size * span, split sign ----------
   logic             s3_valid_ff;
   logic [NUM_W-1:0] s3_mag_ff [2];
   logic             s3_neg_ff [2];
   logic [NUM_W-1:0] s3_mag_in [2];
   logic             s3_neg_in [2];
   logic signed [PROD_W-1:0] s3_prod [2];
   logic signed [PROD_W-1:0] s3_abs  [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         s3_prod[a]   = $signed({1'b0, size[a]}) * s2_span_ff[a];
         s3_neg_in[a] = s3_prod[a][PROD_W-1];
         s3_abs[a]    = s3_neg_in[a] ? -s3_prod[a] : s3_prod[a];
         s3_mag_in[a] = s3_abs[a][NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
      if (adv) begin
         s3_mag_ff <= s3_mag_in;
         s3_neg_ff <= s3_neg_in;
      end
   end

   // ---------------- stages 4..40: restoring divider, one bit each ---------
   logic             dv_valid_ff [DIV_STAGES];
   logic [NUM_W-1:0] dv_dvd_ff   [2][DIV_STAGES];
   logic [NUM_W-1:0] dv_q_ff     [2][DIV_STAGES];
   logic [DEN_W-1:0] dv_rem_ff   [2][DIV_STAGES];
   logic             dv_neg_ff   [2][DIV_STAGES];
   logic [NUM_W-1:0] dv_dvd_in   [2][DIV_STAGES];
   logic [NUM_W-1:0] dv_q_in     [2][DIV_STAGES];
   logic [DEN_W-1:0] dv_rem_in   [2][DIV_STAGES];
   logic             dv_neg_in   [2][DIV_STAGES];

   always_comb begin
      logic [NUM_W-1:0] pd, pq;
      logic [DEN_W-1:0] pr;
      logic             pn;
      logic [DEN_W:0]   t;
      logic             ge;
      for (int a = 0; a < 2; a++) begin
         for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
               pd = s3_mag_ff[a];
               pq = '0;
               pr = '0;
               pn = s3_neg_ff[a];
            end else begin
               pd = dv_dvd_ff[a][j-1];
               pq = dv_q_ff[a][j-1];
               pr = dv_rem_ff[a][j-1];
               pn = dv_neg_ff[a][j-1];
            end
            t  = {pr, pd[NUM_W-1]};
            ge = t >= {1'b0, den[a]};
            dv_rem_in[a][j] = ge ? DEN_W'(t - {1'b0, den[a]}) : t[DEN_W-1:0];
            dv_dvd_in[a][j] = {pd[NUM_W-2:0], 1'b0};
            dv_q_in[a][j]   = {pq[NUM_W-2:0], ge};
            dv_neg_in[a][j] = pn;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (reset) dv_valid_ff[j] <= 1'b0;
         else if (adv) dv_valid_ff[j] <= (j == 0) ? s3_valid_ff : dv_valid_ff[j-1];
      end
      if (adv) begin
         dv_dvd_ff <= dv_dvd_in;
         dv_q_ff   <= dv_q_in;
         dv_rem_ff <= dv_rem_in;
         dv_neg_ff <= dv_neg_in;
      end
   end

   // ---------------- stage 41: floor correction of the quotient ----------
   logic                   fx_valid_ff;
   logic signed [PT_W-1:0] fx_pt_ff [2];
   logic signed [PT_W-1:0] fx_pt_in [2];

   always_comb begin
      logic signed [PT_W-1:0] q;
      for (int a = 0; a < 2; a++) begin
         q = $signed({1'b0, dv_q_ff[a][DIV_STAGES-1]});
         if (dv_neg_ff[a][DIV_STAGES-1])
            fx_pt_in[a] = -q - ((dv_rem_ff[a][DIV_STAGES-1] != '0) ?
                                PT_W'(1) : PT_W'(0));
         else
            fx_pt_in[a] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fx_valid_ff <= 1'b0;
      else if (adv) fx_valid_ff <= dv_valid_ff[DIV_STAGES-1];
      if (adv) fx_pt_ff <= fx_pt_in;
   end

   // ---------------- stage 42: nine products ----------------
   logic                    mu_valid_ff;
   logic signed [MUL_W-1:0] mu_ff [3][3];
   logic signed [MUL_W-1:0] mu_in [3][3];

   always_comb begin
      logic signed [PT_W-1:0]  p [3];
      logic signed [ROT_W-1:0] e;
      p[0] = fx_pt_ff[0];
      p[1] = fx_pt_ff[1];
      p[2] = $signed(PT_W'(zf_ff));
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            e = $signed(rot_ff[r][ROW_W-1-ROT_W*c -: ROT_W]);
            mu_in[r][c] = p[c] * e;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) mu_valid_ff <= 1'b0;
      else if (adv) mu_valid_ff <= fx_valid_ff;
      if (adv) mu_ff <= mu_in;
   end

   // ---------------- stage 43: row sums ----------------
   logic                    ac_valid_ff;
   logic signed [ACC_W-1:0] ac_ff [3];
   logic signed [ACC_W-1:0] ac_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         ac_in[r] = ACC_W'(mu_ff[r][0]) + ACC_W'(mu_ff[r][1]) + ACC_W'(mu_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ac_valid_ff <= 1'b0;
      else if (adv) ac_valid_ff <= mu_valid_ff;
      if (adv) ac_ff <= ac_in;
   end

   // ---------------- stage 44: floor shift, saturate, output register -------
   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_ff [3];
   logic signed [OUT_W-1:0] out_in [3];

   always_comb begin
      logic signed [SHR_W-1:0] s;
      for (int r = 0; r < 3; r++) begin
         s = SHR_W'(ac_ff[r] >>> ROT_FRAC);
         if (s > $signed(SHR_W'({1'b0, {(OUT_W-1){1'b1}}})))
            out_in[r] = {1'b0, {(OUT_W-1){1'b1}}};
         else if (s < -$signed(SHR_W'({1'b1, {(OUT_W-1){1'b0}}})))
            out_in[r] = {1'b1, {(OUT_W-1){1'b0}}};
         else
            out_in[r] = s[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= ac_valid_ff;
      if (adv) out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_dir_x = out_ff[0];
   assign rsp_dir_y = out_ff[1];
   assign rsp_dir_z = out_ff[2];

endmodule

@@ rtl/prdg_checker.sv @@
`timescale 1ns / 1ps
module prdg_port_checker import prdg_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_dir_x
);

   // Reset empties the pipe.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // An empty output never blocks the input.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // A waiting rsp beat stalls the input side.
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("req accepted while pipe stalled");

   // A stalled rsp beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_dir_x)))
      else $error("rsp beat changed while stalled");

endmodule

bind primary_ray_direction_generator_unit prdg_port_checker u_prdg_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_dir_x (rsp_dir_x)
);
